/* rtl/wht_pkg.sv */
// Shared types and constants for the Walsh-Hadamard transform block.
// No dependencies; imported by the controller and the address generator.
`default_nettype none

package wht_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_LOG_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INPUT_MODE = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [2:0] LOG_SIZE_RESET   = 3'd6;
  localparam logic       INPUT_MODE_RESET = 1'b0;

  // Input modes.
  localparam logic MODE_AS_IS    = 1'b0;
  localparam logic MODE_BOOLEAN  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_RD,
    ST_BF_WLO,
    ST_BF_WHI,
    ST_EMIT
  } wht_state_e;

  // Commands from the sequencer to the butterfly address generator.
  typedef struct packed {
    logic clear;
    logic advance;
  } agu_cmd_t;

endpackage

`default_nettype wire

/* rtl/wht_store.sv */
// Vector store: one write port and two read ports with registered read data.
// Stand-alone; used by the top level for loading, butterflies and readout.
`default_nettype none

module wht_store #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [DW-1:0] rdata_a_o,
  output logic      [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two synchronous read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/wht_agu.sv */
// Butterfly address generator: walks stages h = 1 .. n/2 and the n/2 pairs
// of each stage. Depends on wht_pkg for the command struct.
`default_nettype none

module wht_agu
  import wht_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = 6
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [$clog2(MAX_LOG_SIZE+1)-1:0]      ls_i,
  input  wire agu_cmd_t                               cmd_i,
  output logic      [MAX_LOG_SIZE-1:0]                lo_addr_o,
  output logic      [MAX_LOG_SIZE-1:0]                hi_addr_o,
  output logic                                        done_o
);

  localparam int unsigned AW = MAX_LOG_SIZE;
  localparam int unsigned CW = MAX_LOG_SIZE + 1;
  localparam int unsigned SW = $clog2(MAX_LOG_SIZE + 1);

  logic [SW-1:0] stage_q, stage_d;
  logic [AW-1:0] pair_q, pair_d;
  logic [CW-1:0] half;
  logic [AW-1:0] span;
  logic [AW-1:0] low_mask;
  logic          last_in_stage;

  // Pair index k becomes lo by inserting a zero at bit position stage.
  always_comb begin
    half          = (CW'(1) << ls_i) >> 1;
    span          = AW'(1) << stage_q;
    low_mask      = span - AW'(1);
    lo_addr_o     = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask);
    hi_addr_o     = lo_addr_o | span;
    last_in_stage = ({1'b0, pair_q} == (half - CW'(1)));
    done_o        = last_in_stage && ((stage_q + SW'(1)) == ls_i);
  end

  // Counter update.
  always_comb begin
    stage_d = stage_q;
    pair_d  = pair_q;
    if (cmd_i.clear) begin
      stage_d = '0;
      pair_d  = '0;
    end else if (cmd_i.advance) begin
      if (last_in_stage) begin
        pair_d  = '0;
        stage_d = stage_q + SW'(1);
      end else begin
        pair_d = pair_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      pair_q  <= '0;
    end else begin
      stage_q <= stage_d;
      pair_q  <= pair_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/walsh_hadamard_transform_int.sv */
// Top level of the integer fast Walsh-Hadamard transform.
// Depends on wht_pkg, wht_store and wht_agu.
//
// Usage: samples enter on the input channel (in_valid_i / in_stall_o, payload
// sample_i), one word per element in index order, n = 2^log_size per vector.
// Coefficients leave on the output channel (out_valid_o / out_stall_i) in
// natural order with their position and a last flag on the final word.
// Registers log_size (index 0) and input_mode (index 1) are written on the
// cfg channel, which is always ready; write them only while the block idles.
// Steps for a vector of n = 2^L points:
//   load:      one sample per cycle;
//   transform: (n/2) * L butterflies, each a store read and then two writes, as
//              the vector store has a single write port (sum, then difference);
//   readout:   one store read per coefficient, issued only after the read for the
//              previous coefficient is registered into the output word.
// The first coefficient appears once the transform ends and its store read is registered.
// Samples are not taken during transform and readout; a stalled receiver just
// holds the current coefficient and pauses readout. The last coefficient may
// wait in the output register while the next vector loads.
// Reset clears the sequencer and load count; store contents are undefined.
`default_nettype none

module walsh_hadamard_transform_int
  import wht_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = 6,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Sample input channel.
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [DATA_WIDTH-1:0]   sample_i,
  // Coefficient output channel.
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [DATA_WIDTH-1:0]   coefficient_o,
  output logic      [MAX_LOG_SIZE-1:0] position_o,
  output logic                         last_o,
  // Configuration write channel.
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned AW = MAX_LOG_SIZE;
  localparam int unsigned CW = MAX_LOG_SIZE + 1;
  localparam int unsigned SW = $clog2(MAX_LOG_SIZE + 1);
  localparam int unsigned DW = DATA_WIDTH;

  wht_state_e state_q, state_d;

  logic [2:0]    log_size_q;
  logic          input_mode_q;
  logic [SW-1:0] ls;
  logic [CW-1:0] vec_len;

  logic [CW-1:0] load_cnt_q, load_cnt_d;
  logic [CW-1:0] load_idx;
  logic [CW-1:0] load_next;
  logic          in_acc;
  logic          load_done;
  logic [DW-1:0] sample_mapped;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [DW-1:0] rdata_a, rdata_b;
  logic [DW-1:0] diff_q;

  agu_cmd_t      agu_cmd;
  logic [AW-1:0] lo_addr, hi_addr;
  logic          agu_done;

  logic [AW-1:0] emit_idx_q;
  logic          pend_q;
  logic          emit_issue;
  logic          emit_last;
  logic          out_acc;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_size_q   <= LOG_SIZE_RESET;
      input_mode_q <= INPUT_MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOG_SIZE:   log_size_q   <= cfg_data_i[2:0];
        CFG_INPUT_MODE: input_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Active length, with log_size clamped to the store depth.
  always_comb begin
    if (int'(log_size_q) > MAX_LOG_SIZE) begin
      ls = SW'(MAX_LOG_SIZE);
    end else begin
      ls = SW'(log_size_q);
    end
    vec_len = CW'(1) << ls;
  end

  // Sample loading; a count left over from a longer length restarts at zero.
  always_comb begin
    in_acc    = in_valid_i && !in_stall_o;
    load_idx  = (load_cnt_q >= vec_len) ? '0 : load_cnt_q;
    load_next = load_idx + CW'(1);
    load_done = (load_next == vec_len);
    if (input_mode_q == MODE_BOOLEAN) begin
      sample_mapped = (sample_i == '0) ? DW'(1) : '1;
    end else begin
      sample_mapped = sample_i;
    end
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    if (in_acc) begin
      load_cnt_d = load_done ? '0 : load_next;
    end
  end

  // Readout handshake helpers.
  always_comb begin
    out_acc    = out_valid_o && !out_stall_i;
    emit_issue = (state_q == ST_EMIT) && !pend_q && (!out_valid_o || !out_stall_i);
    emit_last  = ({1'b0, emit_idx_q} == (vec_len - CW'(1)));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && load_done) begin
          state_d = (ls == '0) ? ST_EMIT : ST_BF_RD;
        end
      end
      ST_BF_RD:  state_d = ST_BF_WLO;
      ST_BF_WLO: state_d = ST_BF_WHI;
      ST_BF_WHI: state_d = agu_done ? ST_EMIT : ST_BF_RD;
      ST_EMIT: begin
        if (pend_q && emit_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Sequencer outputs: store ports and address generator commands.
  always_comb begin
    in_stall_o      = (state_q != ST_LOAD);
    mem_we          = 1'b0;
    mem_waddr       = lo_addr;
    mem_wdata       = rdata_a + rdata_b;
    mem_raddr_a     = lo_addr;
    agu_cmd.clear   = 1'b0;
    agu_cmd.advance = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        mem_we        = in_acc;
        mem_waddr     = load_idx[AW-1:0];
        mem_wdata     = sample_mapped;
        agu_cmd.clear = in_acc && load_done;
      end
      ST_BF_RD: ;
      ST_BF_WLO: begin
        mem_we = 1'b1;
      end
      ST_BF_WHI: begin
        mem_we          = 1'b1;
        mem_waddr       = hi_addr;
        mem_wdata       = diff_q;
        agu_cmd.advance = 1'b1;
      end
      ST_EMIT: begin
        mem_raddr_a = emit_idx_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      emit_idx_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      pend_q     <= emit_issue;
      if (pend_q) begin
        out_valid_o <= 1'b1;
        emit_idx_q  <= emit_last ? '0 : emit_idx_q + AW'(1);
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers: butterfly difference and the output word.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BF_WLO) begin
      diff_q <= rdata_a - rdata_b;
    end
    if (pend_q) begin
      coefficient_o <= rdata_a;
      position_o    <= emit_idx_q;
      last_o        <= emit_last;
    end
  end

  wht_store #(
    .AW(AW),
    .DW(DW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (hi_addr),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  wht_agu #(
    .MAX_LOG_SIZE(MAX_LOG_SIZE)
  ) u_agu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ls_i      (ls),
    .cmd_i     (agu_cmd),
    .lo_addr_o (lo_addr),
    .hi_addr_o (hi_addr),
    .done_o    (agu_done)
  );

endmodule

`default_nettype wire

/* rtl/wht_checker.sv */
// Port-level checks for walsh_hadamard_transform_int, bound to the top level.
// Depends on wht_pkg for the configuration port widths.
`default_nettype none

module wht_checker
  import wht_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = 6,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic [DATA_WIDTH-1:0]   sample_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [DATA_WIDTH-1:0]   coefficient_o,
  input wire logic [MAX_LOG_SIZE-1:0] position_o,
  input wire logic                    last_o,
  input wire logic                    cfg_valid_i,
  input wire logic                    cfg_ready_o,
  input wire logic [CfgIdxW-1:0]      cfg_index_i,
  input wire logic [CfgDataW-1:0]     cfg_data_i
);

  // A stalled output word holds its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coefficient_o)
      && $stable(position_o) && $stable(last_o))
    else $error("stalled output word changed");

  // No sample is taken while a vector is still being read out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("sample taken during readout");

  // Each coefficient needs a store read, so a taken word leaves a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("output word appeared without a store read");

endmodule

bind walsh_hadamard_transform_int wht_checker #(
  .MAX_LOG_SIZE(MAX_LOG_SIZE),
  .DATA_WIDTH(DATA_WIDTH)
) u_wht_checker (.*);

`default_nettype wire
